// ----- hw/rtl/vn_pkg.sv -----
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types and fixed widths for the 3D vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

   // Width of one input component and of one output component.
   localparam int IN_W  = 16;
   localparam int OUT_W = 16;
   localparam int LANES = 3;

   // One input item: a three-component vector.
   typedef struct packed {
      logic signed [IN_W-1:0] comp_x;
      logic signed [IN_W-1:0] comp_y;
      logic signed [IN_W-1:0] comp_z;
   } req_type;

   // One result item: the unit vector and the zero-length flag.
   typedef struct packed {
      logic signed [OUT_W-1:0] unit_x;
      logic signed [OUT_W-1:0] unit_y;
      logic signed [OUT_W-1:0] unit_z;
      logic                    zero_length;
   } rsp_type;

endpackage

// ----- hw/rtl/vn_div.sv -----
// ----------------------------------------------------------------------------
// vn_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module vn_div #(
   parameter int SW    = 32,
   parameter int QW    = 29,
   parameter int TAG_W = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [SW-1:0]    in_rem,
   input  logic             in_lsb,
   input  logic [SW-1:0]    in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [QW-1:0]    out_quo,
   output logic [TAG_W-1:0] out_tag
);

   // Stage registers; stage 0 is the module input.
   logic             valid_ff [1:QW];
   logic [SW-1:0]    rem_ff   [1:QW];
   logic [SW-1:0]    den_ff   [1:QW];
   logic [QW-1:0]    quo_ff   [1:QW];
   logic [TAG_W-1:0] tag_ff   [1:QW];

   logic             valid_cur [0:QW-1];
   logic [SW-1:0]    rem_cur   [0:QW-1];
   logic [SW-1:0]    den_cur   [0:QW-1];
   logic [QW-1:0]    quo_cur   [0:QW-1];
   logic [TAG_W-1:0] tag_cur   [0:QW-1];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic          nb;
      logic [SW:0]   rt;
      logic [SW:0]   diff;
      logic          ge;
      logic [SW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      // Select this stage's operands.
      if (i == 0) begin : g_first
         assign valid_cur[i] = in_valid;
         assign rem_cur[i]   = in_rem;
         assign den_cur[i]   = in_den;
         assign quo_cur[i]   = '0;
         assign tag_cur[i]   = in_tag;
         assign nb           = in_lsb;
      end else begin : g_next
         assign valid_cur[i] = valid_ff[i];
         assign rem_cur[i]   = rem_ff[i];
         assign den_cur[i]   = den_ff[i];
         assign quo_cur[i]   = quo_ff[i];
         assign tag_cur[i]   = tag_ff[i];
         assign nb           = 1'b0;
      end

      // Shift in the next dividend bit and try one subtraction.
      assign rt     = {rem_cur[i], nb};
      assign diff   = rt - {1'b0, den_cur[i]};
      assign ge     = rt >= {1'b0, den_cur[i]};
      assign rem_in = ge ? diff[SW-1:0] : rt[SW-1:0];
      assign quo_in = {quo_cur[i][QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_cur[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1] <= rem_in;
            den_ff[i+1] <= den_cur[i];
            quo_ff[i+1] <= quo_in;
            tag_ff[i+1] <= tag_cur[i];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

// ----- hw/rtl/vn_sqrt.sv -----
// ----------------------------------------------------------------------------
// vn_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module vn_sqrt #(
   parameter int QW    = 29,
   parameter int TAG_W = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [QW-1:0]          in_rad,
   input  logic [TAG_W-1:0]       in_tag,
   output logic                   out_valid,
   output logic [(QW+1)/2-1:0]    out_root,
   output logic [TAG_W-1:0]       out_tag
);

   localparam int RW = (QW + 1) / 2;
   localparam int PW = 2 * RW;

   logic             valid_ff [1:RW];
   logic [PW-1:0]    rad_ff   [1:RW];
   logic [RW:0]      rem_ff   [1:RW];
   logic [RW-1:0]    root_ff  [1:RW];
   logic [TAG_W-1:0] tag_ff   [1:RW];

   logic             valid_cur [0:RW-1];
   logic [PW-1:0]    rad_cur   [0:RW-1];
   logic [RW:0]      rem_cur   [0:RW-1];
   logic [RW-1:0]    root_cur  [0:RW-1];
   logic [TAG_W-1:0] tag_cur   [0:RW-1];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic [RW+2:0] rs;
      logic [RW+2:0] trial;
      logic [RW+2:0] diff;
      logic          ge;

      if (i == 0) begin : g_first
         assign valid_cur[i] = in_valid;
         assign rad_cur[i]   = PW'(in_rad);
         assign rem_cur[i]   = '0;
         assign root_cur[i]  = '0;
         assign tag_cur[i]   = in_tag;
      end else begin : g_next
         assign valid_cur[i] = valid_ff[i];
         assign rad_cur[i]   = rad_ff[i];
         assign rem_cur[i]   = rem_ff[i];
         assign root_cur[i]  = root_ff[i];
         assign tag_cur[i]   = tag_ff[i];
      end

      // Bring down two radicand bits and test the next root bit.
      assign rs    = {rem_cur[i], rad_cur[i][PW-1 -: 2]};
      assign trial = {1'b0, root_cur[i], 2'b01};
      assign diff  = rs - trial;
      assign ge    = rs >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_cur[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[i+1]  <= {rad_cur[i][PW-3:0], 2'b00};
            rem_ff[i+1]  <= ge ? diff[RW:0] : rs[RW:0];
            root_ff[i+1] <= {root_cur[i][RW-2:0], ge};
            tag_ff[i+1]  <= tag_cur[i];
         end
      end
   end

   assign out_valid = valid_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_tag   = tag_ff[RW];

endmodule

// ----- hw/rtl/vector3_normalize.sv -----
// ----------------------------------------------------------------------------
// vector3_normalize
// Scales a signed three-component vector to unit length in fixed point.
// ----------------------------------------------------------------------------
// Usage: one vector enters on the req_ channel when req_valid is high and
// req_stall is low. Each component c comes out as c * 2^FRAC_BITS / length,
// truncated toward zero, on the rsp_ channel. A vector of length zero gives
// zero components with zero_length set.
// Throughput is one item per cycle while the output is not stalled. Front
// stages form the magnitudes, the squares and their sum; then come a divider
// stage for each quotient bit of squared component over squared length, a
// root stage for each root bit of that quotient, and the output register.
// The whole pipeline moves as one: while rsp_valid is high and rsp_stall is
// high, every stage holds and req_stall is high, so nothing is lost.
// Reset clears every valid bit; the data registers are not reset.
// ----------------------------------------------------------------------------
module vector3_normalize #(
   parameter int FRAC_BITS = 14
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  vn_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output vn_pkg::rsp_type rsp_data
);

   localparam int IW    = vn_pkg::IN_W;
   localparam int MW    = 2 * IW - 1;
   localparam int SW    = 2 * IW;
   localparam int QW    = 2 * FRAC_BITS + 1;
   localparam int RW    = FRAC_BITS + 1;
   localparam int TAG_W = 2;

   logic advance;

   logic            a_valid_ff;
   logic [IW-1:0]   mag_ff [0:vn_pkg::LANES-1];
   logic            neg_a_ff [0:vn_pkg::LANES-1];

   logic            b_valid_ff;
   logic [MW-1:0]   sq_ff [0:vn_pkg::LANES-1];
   logic            neg_b_ff [0:vn_pkg::LANES-1];

   logic            c_valid_ff;
   logic [SW-1:0]   sum_ff;
   logic            zero_c_ff;
   logic [SW-1:0]   rem_c_ff [0:vn_pkg::LANES-1];
   logic            lsb_c_ff [0:vn_pkg::LANES-1];
   logic            neg_c_ff [0:vn_pkg::LANES-1];

   logic signed [IW-1:0] comp [0:vn_pkg::LANES-1];
   logic                 lane_valid [0:vn_pkg::LANES-1];
   logic [RW-1:0]        lane_root  [0:vn_pkg::LANES-1];
   logic [TAG_W-1:0]     lane_tag   [0:vn_pkg::LANES-1];
   logic signed [vn_pkg::OUT_W-1:0] unit [0:vn_pkg::LANES-1];

   logic            rsp_valid_ff;
   vn_pkg::rsp_type rsp_data_ff;
   vn_pkg::rsp_type rsp_data_in;

   // The pipeline moves unless a finished item is waiting on a stall.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign comp[0] = req_data.comp_x;
   assign comp[1] = req_data.comp_y;
   assign comp[2] = req_data.comp_z;

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // Squared length, shared by all three lanes.
   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff    <= SW'({1'b0, sq_ff[0]}) + SW'({1'b0, sq_ff[1]}) + SW'({1'b0, sq_ff[2]});
         zero_c_ff <= (sq_ff[0] == '0) && (sq_ff[1] == '0) && (sq_ff[2] == '0);
      end
   end

   for (genvar k = 0; k < vn_pkg::LANES; k++) begin : g_lane
      logic [2*IW-1:0]    prod;
      logic               div_valid;
      logic [QW-1:0]      div_quo;
      logic [TAG_W-1:0]   div_tag;
      logic signed [RW:0] sv;

      assign prod = mag_ff[k] * mag_ff[k];

      // Magnitude, square, and the divider's starting remainder.
      always_ff @(posedge clock) begin
         if (advance) begin
            mag_ff[k]   <= comp[k][IW-1] ? IW'(-comp[k]) : IW'(comp[k]);
            neg_a_ff[k] <= comp[k][IW-1];
            sq_ff[k]    <= prod[MW-1:0];
            neg_b_ff[k] <= neg_a_ff[k];
            rem_c_ff[k] <= SW'(sq_ff[k][MW-1:1]);
            lsb_c_ff[k] <= sq_ff[k][0];
            neg_c_ff[k] <= neg_b_ff[k];
         end
      end

      // Quotient of squared component times 4^FRAC_BITS over squared length.
      vn_div #(
         .SW    (SW),
         .QW    (QW),
         .TAG_W (TAG_W)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (c_valid_ff),
         .in_rem    (rem_c_ff[k]),
         .in_lsb    (lsb_c_ff[k]),
         .in_den    (sum_ff),
         .in_tag    ({zero_c_ff, neg_c_ff[k]}),
         .out_valid (div_valid),
         .out_quo   (div_quo),
         .out_tag   (div_tag)
      );

      // Its integer square root is the truncated unit magnitude.
      vn_sqrt #(
         .QW    (QW),
         .TAG_W (TAG_W)
      ) u_sqrt (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (div_valid),
         .in_rad    (div_quo),
         .in_tag    (div_tag),
         .out_valid (lane_valid[k]),
         .out_root  (lane_root[k]),
         .out_tag   (lane_tag[k])
      );

      // Restore the sign and fit to the output width.
      assign sv      = lane_tag[k][0] ? -$signed({1'b0, lane_root[k]})
                                      : $signed({1'b0, lane_root[k]});
      assign unit[k] = lane_tag[k][1] ? '0 : vn_pkg::OUT_W'(sv);
   end

   always_comb begin
      rsp_data_in.unit_x      = unit[0];
      rsp_data_in.unit_y      = unit[1];
      rsp_data_in.unit_z      = unit[2];
      rsp_data_in.zero_length = lane_tag[0][1];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= lane_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/vn_checker.sv -----
// ----------------------------------------------------------------------------
// vn_checker
// Port-level checks for the 3D vector normalizer, bound to its top level.
// ----------------------------------------------------------------------------
module vn_checker #(
   parameter int FRAC_BITS = 14
) (
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input vn_pkg::rsp_type rsp_data
);

   localparam logic signed [vn_pkg::OUT_W-1:0] ONE =
      vn_pkg::OUT_W'(1 << ((FRAC_BITS < 14) ? FRAC_BITS : 14));

   // A stalled item holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // Input is held off while a result waits on a stall.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output stalled");

   // A zero-length vector gives zero components.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         rsp_data.unit_x == '0 && rsp_data.unit_y == '0 && rsp_data.unit_z == '0)
      else $error("zero-length item with nonzero components");

   // Unit components never exceed one in magnitude.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && FRAC_BITS <= 14 |->
         rsp_data.unit_x <= ONE && rsp_data.unit_x >= -ONE &&
         rsp_data.unit_y <= ONE && rsp_data.unit_y >= -ONE &&
         rsp_data.unit_z <= ONE && rsp_data.unit_z >= -ONE)
      else $error("unit component out of range");

   // No result leaves right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind vector3_normalize vn_checker #(.FRAC_BITS(FRAC_BITS)) u_vn_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
